// ===== rtl/core/plns_pkg.sv =====
`timescale 1ns / 1ps

package plns_pkg;

  // Field widths of the channels and the configuration register
  localparam int OPCODE_W = 2;
  localparam int COORD_W  = 6;
  localparam int SITE_W   = 16;
  localparam int REACH_W  = 4;
  localparam int RESULT_W = 32;
  localparam int LEN_W    = 7;

  // Span counters hold up to 2*reach
  localparam int SPAN_W = REACH_W + 1;

  // Defaults for the top level parameters
  localparam int MAX_SIDE_DEF   = 64;
  localparam int MAX_REACH_DEF  = 15;
  localparam int VALUE_BITS_DEF = 16;

  // Side length after reset
  localparam logic [LEN_W-1:0] SIDE_RESET = LEN_W'(64);

  // Command queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_FILL  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_SUM   = 2'd3;

  // Classified command, reach already clamped
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [SITE_W-1:0]   site_value;
    logic [REACH_W-1:0]  reach;
  } cmd_t;

endpackage

// ===== rtl/core/plns_channels.sv =====
`timescale 1ns / 1ps

// Input channel: one command per beat
interface plns_in_if;
  logic                                valid;
  logic                                ready;
  logic [plns_pkg::OPCODE_W-1:0]       opcode;
  logic [plns_pkg::COORD_W-1:0]        col;
  logic [plns_pkg::COORD_W-1:0]        row;
  logic signed [plns_pkg::SITE_W-1:0]  site_value;
  logic [plns_pkg::REACH_W-1:0]        reach;

  modport source (output valid, opcode, col, row, site_value, reach, input ready);
  modport sink   (input valid, opcode, col, row, site_value, reach, output ready);
endinterface

// Result channel: one result per beat
interface plns_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [plns_pkg::RESULT_W-1:0] answer;
  logic signed [plns_pkg::RESULT_W-1:0] total;

  modport source (output valid, answer, total, input ready);
  modport sink   (input valid, answer, total, output ready);
endinterface

// ===== rtl/core/plns_front.sv =====
`timescale 1ns / 1ps

module plns_front #(
  parameter int MAX_REACH = plns_pkg::MAX_REACH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [plns_pkg::LEN_W-1:0] side_len,
  input  logic                       clearing,
  plns_in_if.sink                    in_ch,
  output logic                       q_push,
  output plns_pkg::cmd_t             q_cmd,
  input  logic                       q_full
);

  localparam int LW = plns_pkg::LEN_W;
  localparam logic [LW-1:0] REACH_CAP = LW'(MAX_REACH);

  logic                         stage_v_r;
  plns_pkg::cmd_t               stage_r;
  logic [LW-1:0]                len_m1;
  logic [LW-1:0]                reach_lim;
  logic [plns_pkg::REACH_W-1:0] reach_c;
  logic                         accept;

  // Reach limit: MAX_REACH and side length minus one
  always_comb begin
    len_m1    = side_len - LW'(1);
    reach_lim = (len_m1 < REACH_CAP) ? len_m1 : REACH_CAP;
    reach_c   = (LW'(in_ch.reach) > reach_lim) ? plns_pkg::REACH_W'(reach_lim) : in_ch.reach;
  end

  // Stage drains into the queue whenever it has room
  assign q_push      = stage_v_r && !q_full;
  assign q_cmd       = stage_r;
  assign in_ch.ready = (!stage_v_r || !q_full) && !clearing;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (accept) begin
      stage_v_r <= 1'b1;
    end else if (q_push) begin
      stage_v_r <= 1'b0;
    end
  end

  // Classified command, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r.opcode     <= in_ch.opcode;
      stage_r.col        <= in_ch.col;
      stage_r.row        <= in_ch.row;
      stage_r.site_value <= in_ch.site_value;
      stage_r.reach      <= reach_c;
    end
  end

endmodule

// ===== rtl/core/plns_queue.sv =====
`timescale 1ns / 1ps

module plns_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  plns_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output plns_pkg::cmd_t head
);

  localparam int PW = $clog2(plns_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(plns_pkg::QUEUE_DEPTH + 1);

  plns_pkg::cmd_t entries_r [plns_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [CW-1:0]  count_r;

  assign full  = (count_r == CW'(plns_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = entries_r[rd_ptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// ===== rtl/core/plns_back.sv =====
`timescale 1ns / 1ps

module plns_back #(
  parameter int MAX_SIDE   = plns_pkg::MAX_SIDE_DEF,
  parameter int VALUE_BITS = plns_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [plns_pkg::LEN_W-1:0] side_len,
  input  logic                       q_empty,
  input  plns_pkg::cmd_t             q_head,
  output logic                       q_pop,
  output logic                       clearing,
  plns_out_if.source                 out_ch
);

  localparam int LW    = plns_pkg::LEN_W;
  localparam int SW    = plns_pkg::SPAN_W;
  localparam int RW    = plns_pkg::RESULT_W;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] SWEEP_END = AW'(DEPTH - 1);

  // Sequencer states
  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_MOD     = 4'd2;
  localparam logic [3:0] S_RDISSUE = 4'd3;
  localparam logic [3:0] S_RDUSE   = 4'd4;
  localparam logic [3:0] S_FILL    = 4'd5;
  localparam logic [3:0] S_SUM     = 4'd6;
  localparam logic [3:0] S_DRAIN   = 4'd7;
  localparam logic [3:0] S_OUT     = 4'd8;

  logic [3:0]            state_r, state_nxt;
  plns_pkg::cmd_t        cmd_r;
  logic [LW-1:0]         c_r, r_r;
  logic [LW-1:0]         x_r, y_r, y0_r;
  logic [SW-1:0]         u_r, v_r;
  logic [AW-1:0]         addr_r;
  logic [AW-1:0]         sweep_r;
  logic [AW-1:0]         sweep_last_r;
  logic signed [RW-1:0]  total_r;
  logic signed [RW-1:0]  acc_r;
  logic                  pend_r;
  logic                  take_r;
  logic [VALUE_BITS-1:0] rdata_r;
  logic                  out_valid_r;
  logic signed [RW-1:0]  out_answer_r;
  logic signed [RW-1:0]  out_total_r;

  logic [VALUE_BITS-1:0] mem [DEPTH];

  logic [LW-1:0]                px, py;
  logic [2*LW-1:0]              lin_full;
  logic [AW-1:0]                mem_raddr;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [VALUE_BITS-1:0]        mem_wdata;
  logic [RW-1:0]                val_raw;
  logic signed [VALUE_BITS-1:0] val_s;
  logic signed [VALUE_BITS-1:0] rd_s;
  logic signed [RW-1:0]         val32;
  logic signed [RW-1:0]         rd32;
  logic                         mod_done;
  logic [LW:0]                  xs, ys;
  logic [LW-1:0]                x_start, y_start;
  logic [LW-1:0]                len_m1;
  logic [LW-1:0]                x_inc, y_inc;
  logic [SW-1:0]                span_last;
  logic                         out_free;

  assign clearing = (state_r == S_CLEAR);
  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign out_free = !out_valid_r || out_ch.ready;
  assign len_m1   = side_len - LW'(1);

  // Value extension: field bits taken to VALUE_BITS, then signed to 32
  assign val_raw = RW'(cmd_r.site_value);
  assign val_s   = val_raw[VALUE_BITS-1:0];
  assign val32   = RW'(val_s);
  assign rd_s    = rdata_r;
  assign rd32    = RW'(rd_s);

  // Shared site address: px + py * side; (len-1, len-1) gives the last fill site
  always_comb begin
    px = c_r;
    py = r_r;
    if (state_r == S_SUM) begin
      px = x_r;
      py = y_r;
    end else if (cmd_r.opcode == plns_pkg::OP_FILL) begin
      px = len_m1;
      py = len_m1;
    end
    lin_full = (2*LW)'(px) + (2*LW)'(py) * (2*LW)'(side_len);
  end

  // Coordinate reduction and neighborhood start corner
  always_comb begin
    mod_done = (c_r < side_len) && (r_r < side_len);
    xs = {1'b0, c_r} + {1'b0, side_len} - (LW+1)'(cmd_r.reach);
    ys = {1'b0, r_r} + {1'b0, side_len} - (LW+1)'(cmd_r.reach);
    x_start = (xs >= {1'b0, side_len}) ? LW'(xs - {1'b0, side_len}) : LW'(xs);
    y_start = (ys >= {1'b0, side_len}) ? LW'(ys - {1'b0, side_len}) : LW'(ys);
    x_inc = (x_r == len_m1) ? '0 : x_r + LW'(1);
    y_inc = (y_r == len_m1) ? '0 : y_r + LW'(1);
    span_last = {cmd_r.reach, 1'b0};
  end

  // Memory port control
  always_comb begin
    mem_raddr = (state_r == S_SUM) ? AW'(lin_full) : addr_r;
    mem_we    = 1'b0;
    mem_waddr = sweep_r;
    mem_wdata = val_s;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      S_FILL: begin
        mem_we = 1'b1;
      end
      S_RDUSE: begin
        mem_we    = (cmd_r.opcode == plns_pkg::OP_WRITE);
        mem_waddr = addr_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Site memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:   if (sweep_r == SWEEP_END) state_nxt = S_IDLE;
      S_IDLE:    if (!q_empty) state_nxt = S_MOD;
      S_MOD: begin
        if (mod_done) begin
          case (cmd_r.opcode)
            plns_pkg::OP_FILL: state_nxt = S_FILL;
            plns_pkg::OP_SUM:  state_nxt = S_SUM;
            default:           state_nxt = S_RDISSUE;
          endcase
        end
      end
      S_RDISSUE: state_nxt = S_RDUSE;
      S_RDUSE:   state_nxt = S_OUT;
      S_FILL:    if (sweep_r == sweep_last_r) state_nxt = S_OUT;
      S_SUM:     if (v_r == span_last && u_r == span_last) state_nxt = S_DRAIN;
      S_DRAIN:   state_nxt = S_OUT;
      S_OUT:     if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sweep_r     <= '0;
      pend_r      <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == S_SUM);
      case (state_r)
        S_CLEAR:  sweep_r <= sweep_r + AW'(1);
        S_MOD: begin
          if (mod_done && cmd_r.opcode == plns_pkg::OP_FILL) begin
            sweep_r <= '0;
            total_r <= '0;
          end
        end
        S_FILL: begin
          sweep_r <= sweep_r + AW'(1);
          total_r <= total_r + val32;
        end
        S_RDUSE: begin
          if (cmd_r.opcode == plns_pkg::OP_WRITE) total_r <= total_r + val32 - rd32;
        end
        default: begin
          sweep_r <= sweep_r;
        end
      endcase
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // Neighborhood accumulation takes each read word in the cycle after its read is issued
    if (pend_r && take_r) acc_r <= acc_r + rd32;
    case (state_r)
      S_IDLE: begin
        cmd_r <= q_head;
        c_r   <= LW'(q_head.col);
        r_r   <= LW'(q_head.row);
      end
      S_MOD: begin
        if (!mod_done) begin
          if (c_r >= side_len) c_r <= c_r - side_len;
          if (r_r >= side_len) r_r <= r_r - side_len;
        end else begin
          addr_r       <= AW'(lin_full);
          sweep_last_r <= AW'(lin_full);
          acc_r        <= '0;
          x_r          <= x_start;
          y_r          <= y_start;
          y0_r         <= y_start;
          u_r          <= '0;
          v_r          <= '0;
        end
      end
      S_RDUSE: begin
        if (cmd_r.opcode == plns_pkg::OP_READ) acc_r <= rd32;
      end
      S_SUM: begin
        take_r <= !(x_r == c_r && y_r == r_r);
        if (v_r == span_last) begin
          v_r <= '0;
          y_r <= y0_r;
          u_r <= u_r + SW'(1);
          x_r <= x_inc;
        end else begin
          v_r <= v_r + SW'(1);
          y_r <= y_inc;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_answer_r <= acc_r;
          out_total_r  <= total_r;
        end
      end
      default: begin
        take_r <= take_r;
      end
    endcase
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.answer = out_answer_r;
  assign out_ch.total  = out_total_r;

endmodule

// ===== rtl/core/periodic_lattice_neighbor_sum.sv =====
`timescale 1ns / 1ps

// Periodic lattice store with running total and square-neighborhood sum.
// Commands are taken into a front stage and a two-entry queue, and a back
// sequencer runs them one at a time against a single site memory of
// MAX_SIDE*MAX_SIDE entries with one write and one registered read port.
// Every command returns one result beat. Each command first reduces its
// coordinates by taking the side length off col and row until both are
// below it; read and write then do one read of the site, fill writes each
// of the side^2 sites and a neighborhood sum reads the (2r+1)^2 square,
// r being the clamped reach, one site per cycle. After
// reset a clearing pass zeroes all MAX_SIDE*MAX_SIDE entries and no
// command beat is taken until it ends; side_length may be written meanwhile.
module periodic_lattice_neighbor_sum #(
  parameter int MAX_SIDE   = plns_pkg::MAX_SIDE_DEF,
  parameter int MAX_REACH  = plns_pkg::MAX_REACH_DEF,
  parameter int VALUE_BITS = plns_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  plns_in_if.sink                    in_ch,
  plns_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [plns_pkg::LEN_W-1:0] cfg_wdata
);

  localparam int LW = plns_pkg::LEN_W;

  logic [LW-1:0]  side_len_r;
  logic           clearing;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  plns_pkg::cmd_t q_cmd;
  plns_pkg::cmd_t q_head;

  // Side length in use: zero acts as one, large values as MAX_SIDE
  function automatic logic [LW-1:0] clamp_len(input logic [LW-1:0] v);
    logic [LW-1:0] l;
    l = v;
    if (v == '0) begin
      l = LW'(1);
    end else if (32'(v) > MAX_SIDE) begin
      l = LW'(MAX_SIDE);
    end
    return l;
  endfunction

  // Configuration register, stored already clamped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_len_r <= clamp_len(plns_pkg::SIDE_RESET);
    end else if (cfg_we) begin
      side_len_r <= clamp_len(cfg_wdata);
    end
  end

  plns_front #(
    .MAX_REACH (MAX_REACH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .side_len (side_len_r),
    .clearing (clearing),
    .in_ch    (in_ch),
    .q_push   (q_push),
    .q_cmd    (q_cmd),
    .q_full   (q_full)
  );

  plns_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  plns_back #(
    .MAX_SIDE   (MAX_SIDE),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .side_len (side_len_r),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

`ifndef NO_ASSERTIONS
  // No command beat may slip in while the memory is being cleared
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !clearing)
    else $error("command beat taken during clearing pass");

  // Reset always starts the clearing pass
  assert property (@(posedge clk) !rst_n |=> clearing)
    else $error("clearing pass not started by reset");

  // Front never pushes into a full queue
  assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("push into full command queue");

  // Back pops only what is there
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty command queue");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import plns_pkg::*;

  localparam int SIDE_MAX    = MAX_SIDE_DEF;
  localparam int REACH_MAX   = MAX_REACH_DEF;
  localparam int SITE_COUNT  = SIDE_MAX * SIDE_MAX;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 1000;
  localparam int BURST_ITEMS = 50;

  // Mirror of the lattice: predicts answer and running total per command
  class lattice_mirror;
    typedef struct packed {
      logic signed [RESULT_W-1:0] answer;
      logic signed [RESULT_W-1:0] total;
    } result_t;

    logic signed [SITE_W-1:0]   sites [SITE_COUNT];
    logic signed [RESULT_W-1:0] total;
    logic [LEN_W-1:0]           side;
    result_t                    due_results [$];
    int                         errors;
    int                         results_seen;

    function new();
      foreach (sites[k]) sites[k] = '0;
      total        = '0;
      side         = SIDE_RESET;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_side(logic [LEN_W-1:0] value);
      side = value;
    endfunction

    // Side length as the lattice uses it: zero acts as 1, clamp to max
    function int unsigned lattice_len();
      if (side == 0) return 1;
      if (side > SIDE_MAX) return SIDE_MAX;
      return side;
    endfunction

    function void note_command(cmd_t cmd);
      int unsigned len, col, row, at, reach, span, u, v, x, y, k;
      logic signed [RESULT_W-1:0] value, acc;
      result_t res;
      len   = lattice_len();
      col   = cmd.col % len;
      row   = cmd.row % len;
      at    = col + row * len;
      value = $signed(cmd.site_value);
      acc   = '0;
      case (cmd.opcode)
        OP_FILL: begin
          for (k = 0; k < len * len; k++) sites[k] = cmd.site_value;
          total = value * $signed(RESULT_W'(len * len));
        end
        OP_WRITE: begin
          total = total + value - sites[at];
          sites[at] = cmd.site_value;
        end
        OP_READ: begin
          acc = sites[at];
        end
        default: begin
          // clamp reach; a span wider than the side visits sites repeatedly
          reach = cmd.reach;
          if (reach > REACH_MAX) reach = REACH_MAX;
          if (reach > len - 1) reach = len - 1;
          span = 2 * reach + 1;
          for (u = 0; u < span; u++) begin
            x = (col + len + u - reach) % len;
            for (v = 0; v < span; v++) begin
              y = (row + len + v - reach) % len;
              if (!(x == col && y == row)) acc = acc + sites[x + y * len];
            end
          end
        end
      endcase
      res.answer = acc;
      res.total  = total;
      due_results.push_back(res);
    endfunction

    function void check_result(logic signed [RESULT_W-1:0] answer,
                               logic signed [RESULT_W-1:0] total_out);
      result_t exp_res;
      results_seen++;
      if (due_results.size() == 0) begin
        $error("result beat with none due: answer %0d total %0d", answer, total_out);
        errors++;
        return;
      end
      exp_res = due_results.pop_front();
      if (answer !== exp_res.answer) begin
        $error("answer: expected %0d, got %0d", exp_res.answer, answer);
        errors++;
      end
      if (total_out !== exp_res.total) begin
        $error("total: expected %0d, got %0d", exp_res.total, total_out);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  plns_in_if  in_ch ();
  plns_out_if out_ch ();

  lattice_mirror mirror;
  int commands_sent;
  int send_idle_pct;
  int stall_pct;
  int hold_asks;
  int cycle_count;

  periodic_lattice_neighbor_sum dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Input beats go to the mirror
  always @(posedge clk) begin : cmd_monitor
    cmd_t beat;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      beat.opcode     = in_ch.opcode;
      beat.col        = in_ch.col;
      beat.row        = in_ch.row;
      beat.site_value = in_ch.site_value;
      beat.reach      = in_ch.reach;
      mirror.note_command(beat);
    end
  end

  // Result beats are checked against the mirror
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      mirror.check_result(out_ch.answer, out_ch.total);
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int served;
    served = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != served) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        served++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // One command beat, with random idle cycles ahead of it
  task automatic push_cmd(input logic [OPCODE_W-1:0] op, input logic [COORD_W-1:0] col,
                          input logic [COORD_W-1:0] row, input logic [SITE_W-1:0] value,
                          input logic [REACH_W-1:0] reach);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.col        <= col;
    in_ch.row        <= row;
    in_ch.site_value <= value;
    in_ch.reach      <= reach;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    commands_sent++;
  endtask

  // Stop sending and wait for every due result
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (mirror.results_seen < commands_sent) @(posedge clk);
  endtask

  task automatic set_side_length(input logic [LEN_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    mirror.set_side(value);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SITE_W-1:0] pick_value();
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(3))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return SITE_W'($urandom_range(16'hFFFF));
  endfunction

  // Random commands clustered on a few hot sites so sums see real data
  task automatic random_burst(input int count);
    logic [COORD_W-1:0]  hot_col [4];
    logic [COORD_W-1:0]  hot_row [4];
    logic [OPCODE_W-1:0] op;
    logic [COORD_W-1:0]  col, row;
    int unsigned len, fill_pct, pick, h;
    len      = mirror.lattice_len();
    fill_pct = (len >= 33) ? 3 : 10;
    foreach (hot_col[k]) begin
      hot_col[k] = COORD_W'($urandom_range(len - 1));
      hot_row[k] = COORD_W'($urandom_range(len - 1));
    end
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < fill_pct) op = OP_FILL;
      else if (pick < fill_pct + 35) op = OP_WRITE;
      else if (pick < fill_pct + 60) op = OP_READ;
      else op = OP_SUM;
      pick = $urandom_range(99);
      if (pick < 60) begin
        h   = $urandom_range(3);
        col = hot_col[h];
        row = hot_row[h];
      end else if (pick < 85) begin
        col = COORD_W'($urandom_range(len - 1));
        row = COORD_W'($urandom_range(len - 1));
      end else begin
        col = COORD_W'($urandom_range(63));
        row = COORD_W'($urandom_range(63));
      end
      push_cmd(op, col, row, pick_value(), REACH_W'($urandom_range(15)));
    end
  endtask

  initial begin : stimulus
    int side_plan [12];
    side_plan = '{1, 2, 3, 0, 7, 16, 127, 64, 5, 33, 100, 4};
    mirror           = new();
    commands_sent    = 0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    hold_asks        = 0;
    cycle_count      = 0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_FILL;
    in_ch.col        = '0;
    in_ch.row        = '0;
    in_ch.site_value = '0;
    in_ch.reach      = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: full side, corner sites, wraparound and extremes
    push_cmd(OP_READ,   6'd0,  6'd0,  16'h0000, 4'd0);
    push_cmd(OP_WRITE,  6'd63, 6'd63, 16'h7FFF, 4'd0);
    push_cmd(OP_WRITE,  6'd0,  6'd0,  16'h8000, 4'd0);
    push_cmd(OP_WRITE,  6'd1,  6'd0,  16'h0001, 4'd0);
    push_cmd(OP_WRITE,  6'd0,  6'd1,  16'hFFFF, 4'd0);
    push_cmd(OP_READ,   6'd63, 6'd63, 16'h0000, 4'd0);
    push_cmd(OP_SUM,    6'd0,  6'd0,  16'h0000, 4'd1);
    push_cmd(OP_SUM,    6'd0,  6'd0,  16'h0000, 4'd15);
    push_cmd(OP_SUM,    6'd63, 6'd0,  16'h0000, 4'd0);
    push_cmd(OP_WRITE,  6'd42, 6'd21, 16'h5555, 4'd0);
    push_cmd(OP_READ,   6'd42, 6'd21, 16'hAAAA, 4'd15);
    // Small side: reach clamps, squares wider than the lattice, modulo coords
    drain();
    set_side_length(7'd3);
    push_cmd(OP_SUM,    6'd1,  6'd1,  16'h0000, 4'd15);
    push_cmd(OP_WRITE,  6'd63, 6'd62, 16'h7FFF, 4'd0);
    push_cmd(OP_FILL,   6'd0,  6'd0,  16'h8000, 4'd0);
    push_cmd(OP_WRITE,  6'd2,  6'd2,  16'd100,  4'd0);
    push_cmd(OP_SUM,    6'd0,  6'd0,  16'h0000, 4'd15);
    push_cmd(OP_READ,   6'd5,  6'd5,  16'h0000, 4'd0);
    // Back to full side: old sites seen under the new indexing
    drain();
    set_side_length(7'd64);
    push_cmd(OP_READ,   6'd3,  6'd0,  16'h0000, 4'd0);
    push_cmd(OP_SUM,    6'd0,  6'd0,  16'h0000, 4'd15);
    // Zero side acts as one site
    drain();
    set_side_length(7'd0);
    push_cmd(OP_SUM,    6'd63, 6'd63, 16'h0000, 4'd15);
    push_cmd(OP_WRITE,  6'd63, 6'd63, 16'h1234, 4'd0);
    push_cmd(OP_READ,   6'd17, 6'd40, 16'h0000, 4'd0);

    // Random phases over several side lengths and idle patterns
    foreach (side_plan[p]) begin
      drain();
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 54; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 54; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      set_side_length(LEN_W'(side_plan[p]));
      // long receiver hold-off while the sender keeps going: input backs up
      if (p == 4) hold_asks <= hold_asks + 1;
      random_burst(BURST_ITEMS);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
